// ===== rtl/core/bbcp_pkg.sv =====
// Shared types and constants of the block buffer cache policy.
package bbcp_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int REQ_W = 2;
	localparam int BLK_W = 24;
	localparam int SIDX_W = 4;
	localparam int SIZE_W = 16;
	localparam int CFG_W = 13;
	localparam logic [CFG_W-1:0] MAX_WRITE_RST = 13'd512;

	localparam logic [REQ_W-1:0] REQ_READ = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SYNC = 2'd2;

	localparam logic [2:0] ST_HIT = 3'd0;
	localparam logic [2:0] ST_MISS = 3'd1;
	localparam logic [2:0] ST_SIZE = 3'd2;
	localparam logic [2:0] ST_NORES = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [1:0] L_FREE = 2'd0;
	localparam logic [1:0] L_CLEAN = 2'd1;
	localparam logic [1:0] L_DIRTY = 2'd2;

	// Controller commands to the datapath
	typedef struct packed {
		logic latch;      // capture request fields
		logic lookup;     // register tag match and victim search
		logic hit_move;   // move hit slot to tail of its list
		logic fill;       // load victim with new block, clean tail
		logic wr_move;    // move write slot to dirty tail
		logic sync_move;  // move oldest dirty slot to clean tail
		logic [2:0] emit; // result kind to present
		logic emit_v;
	} bbcp_cmd_t;

	localparam logic [2:0] E_HIT = 3'd0;
	localparam logic [2:0] E_WB = 3'd1;
	localparam logic [2:0] E_FILL = 3'd2;
	localparam logic [2:0] E_WRES = 3'd3;
	localparam logic [2:0] E_SYWB = 3'd4;
	localparam logic [2:0] E_SYDONE = 3'd5;

	// Datapath status to the controller
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic hit;
		logic has_free;
		logic has_clean;
		logic has_dirty;
	} bbcp_sts_t;
endpackage

// ===== rtl/core/bbcp_ctrl.sv =====
// Controller state machine of the block buffer cache policy.
module bbcp_ctrl import bbcp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  bbcp_sts_t sts,
	output bbcp_cmd_t cmd
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOOK = 6'b000010,
		S_FILL = 6'b000100,
		S_SYNC = 6'b001000,
		S_SYLK = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_IDLE;
				case (sts.req)
					REQ_READ: begin
						if (sts.hit) begin
							cmd.hit_move = 1'b1;
							cmd.emit_v = 1'b1;
							cmd.emit = E_HIT;
						end else begin
							if (!sts.has_free && !sts.has_clean) begin
								cmd.emit_v = 1'b1;
								cmd.emit = E_WB;
							end
							state_d = S_FILL;
						end
					end
					REQ_WRITE: begin
						cmd.wr_move = 1'b1;
						cmd.emit_v = 1'b1;
						cmd.emit = E_WRES;
					end
					REQ_SYNC: state_d = S_SYNC;
					default: state_d = S_IDLE;
				endcase
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				cmd.emit_v = 1'b1;
				cmd.emit = E_FILL;
				state_d = S_IDLE;
			end
			S_SYNC: begin
				if (sts.has_dirty) begin
					cmd.sync_move = 1'b1;
					cmd.emit_v = 1'b1;
					cmd.emit = E_SYWB;
					state_d = S_SYLK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SYLK: begin
				cmd.lookup = 1'b1;
				state_d = S_SYNC;
			end
			S_DONE: begin
				cmd.emit_v = 1'b1;
				cmd.emit = E_SYDONE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_IDLE && start) cmd.lookup = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// ===== rtl/core/bbcp_dp.sv =====
// Datapath: tags, list membership, LRU ranks and result register.
module bbcp_dp import bbcp_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [REQ_W-1:0] req_type,
	input  logic [BLK_W-1:0] block_number,
	input  logic [SIDX_W-1:0] slot_index,
	input  logic [SIZE_W-1:0] write_size,
	input  bbcp_cmd_t cmd,
	output bbcp_sts_t sts,
	output logic done,
	output logic [2:0] status,
	output logic [3:0] slot,
	output logic [1:0] device_op,
	output logic [BLK_W-1:0] device_block,
	output logic last
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = $clog2(SLOTS + 1);

	logic [BLK_W-1:0] tag_q [SLOTS];
	logic [1:0] list_q [SLOTS];
	logic [RW-1:0] rank_q [SLOTS];
	logic [CFG_W-1:0] maxw_q;

	logic [REQ_W-1:0] req_q;
	logic [BLK_W-1:0] blk_q;
	logic [SIDX_W-1:0] sidx_q;
	logic [SIZE_W-1:0] size_q;

	// registered lookup results
	logic hit_q, hfree_q, hclean_q, hdirty_q;
	logic [SW-1:0] hit_s_q, vic_q, odirty_q;

	// combinational search over the slots (independent per slot)
	logic hit_c, free_c, clean_c, dirty_c;
	logic [SW-1:0] hit_i, free_i, clean_i, dirty_i;
	logic [BLK_W-1:0] look_blk;

	assign look_blk = cmd.latch ? block_number : blk_q;

	always_comb begin
		hit_c = 1'b0; free_c = 1'b0; clean_c = 1'b0; dirty_c = 1'b0;
		hit_i = '0; free_i = '0; clean_i = '0; dirty_i = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (list_q[i] != L_FREE && tag_q[i] == look_blk) begin
				hit_c = 1'b1; hit_i = SW'(i);
			end
			if (list_q[i] == L_FREE) begin
				free_c = 1'b1; free_i = SW'(i);
			end
			if (list_q[i] == L_CLEAN && rank_q[i] == '0) begin
				clean_c = 1'b1; clean_i = SW'(i);
			end
			if (list_q[i] == L_DIRTY && rank_q[i] == '0) begin
				dirty_c = 1'b1; dirty_i = SW'(i);
			end
		end
	end

	// list sizes
	logic [RW-1:0] n_clean, n_dirty;
	always_comb begin
		n_clean = '0; n_dirty = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (list_q[i] == L_CLEAN) n_clean = n_clean + RW'(1);
			if (list_q[i] == L_DIRTY) n_dirty = n_dirty + RW'(1);
		end
	end

	// move selection
	logic mv;
	logic [SW-1:0] mv_s;
	logic [1:0] mv_l;
	logic wr_ok, wr_size_bad;
	logic [SW-1:0] sidx_n;

	assign sidx_n = SW'(sidx_q);
	assign wr_size_bad = ({3'b0, maxw_q} < size_q);
	assign wr_ok = !wr_size_bad && (32'(sidx_q) < SLOTS) && (list_q[sidx_n] != L_FREE);

	always_comb begin
		mv = 1'b0; mv_s = '0; mv_l = L_CLEAN;
		if (cmd.hit_move) begin
			mv = 1'b1; mv_s = hit_s_q; mv_l = list_q[hit_s_q];
		end else if (cmd.fill) begin
			mv = 1'b1; mv_s = vic_q; mv_l = L_CLEAN;
		end else if (cmd.wr_move && wr_ok) begin
			mv = 1'b1; mv_s = sidx_n; mv_l = L_DIRTY;
		end else if (cmd.sync_move) begin
			mv = 1'b1; mv_s = odirty_q; mv_l = L_CLEAN;
		end
	end

	// state update: unlink then append at tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				list_q[i] <= L_FREE;
				rank_q[i] <= '0;
			end
			maxw_q <= MAX_WRITE_RST;
		end else begin
			if (cfg_valid) maxw_q <= cfg_data;
			if (mv) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (SW'(i) != mv_s && list_q[i] == list_q[mv_s] &&
					    list_q[mv_s] != L_FREE && rank_q[i] > rank_q[mv_s])
						rank_q[i] <= rank_q[i] - RW'(1);
				end
				list_q[mv_s] <= mv_l;
				if (list_q[mv_s] == mv_l)
					rank_q[mv_s] <= ((mv_l == L_CLEAN) ? n_clean : n_dirty) - RW'(1);
				else
					rank_q[mv_s] <= (mv_l == L_CLEAN) ? n_clean : n_dirty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill) tag_q[vic_q] <= blk_q;
	end

	// request capture and lookup register
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			blk_q <= block_number;
			sidx_q <= slot_index;
			size_q <= write_size;
		end
		if (cmd.lookup) begin
			hit_q <= hit_c;
			hit_s_q <= hit_i;
			hfree_q <= free_c;
			hclean_q <= clean_c;
			hdirty_q <= dirty_c;
			odirty_q <= dirty_i;
			vic_q <= free_c ? free_i : (clean_c ? clean_i : dirty_i);
		end
	end

	assign sts.req = req_q;
	assign sts.hit = hit_q;
	assign sts.has_free = hfree_q;
	assign sts.has_clean = hclean_q;
	assign sts.has_dirty = hdirty_q;

	// result register
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.emit_v;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_v) begin
			last <= 1'b1;
			device_op <= OP_NONE;
			device_block <= '0;
			status <= ST_HIT;
			slot <= '0;
			case (cmd.emit)
				E_HIT: slot <= 4'(hit_s_q);
				E_WB: begin
					status <= ST_MISS; slot <= 4'(vic_q); device_op <= OP_WRITE;
					device_block <= tag_q[vic_q]; last <= 1'b0;
				end
				E_FILL: begin
					status <= ST_MISS; slot <= 4'(vic_q); device_op <= OP_READ;
					device_block <= blk_q;
				end
				E_WRES: begin
					slot <= sidx_q;
					status <= wr_size_bad ? ST_SIZE : (wr_ok ? ST_HIT : ST_NORES);
				end
				E_SYWB: begin
					status <= ST_DONE; slot <= 4'(odirty_q); device_op <= OP_WRITE;
					device_block <= tag_q[odirty_q]; last <= 1'b0;
				end
				E_SYDONE: status <= ST_DONE;
				default: status <= ST_HIT;
			endcase
		end
	end
	assign done = done_q;
endmodule

// ===== rtl/core/block_buffer_cache_policy.sv =====
// Top level of the block buffer cache policy.
// Usage:
//   Requests enter on start when busy is low, with req_type, block_number,
//   slot_index and write_size. Results leave on status, slot, device_op,
//   device_block and last, each valid for one cycle while done is high.
//   The receiver cannot stall; every result must be taken when shown.
//   The max write size register takes cfg_data on cfg_valid; cfg_ready
//   is always high. The user must write only while idle (not enforced).
// Request flow:
//   Read hit, write: result registered from LOOK; busy falls as done rises.
//   Read miss: LOOK, FILL; a dirty victim write-back comes the cycle before.
//   Sync: states SYNC and SYLK per dirty slot walked, then DONE; the single
//   lookup register finds the oldest dirty slot each step.
//   Unknown request type: no result, back to idle after LOOK.
// Reset: arst_n clears all slots to free, ranks to zero, max write size to 512.
module block_buffer_cache_policy import bbcp_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [REQ_W-1:0] req_type,
	input  logic [BLK_W-1:0] block_number,
	input  logic [SIDX_W-1:0] slot_index,
	input  logic [SIZE_W-1:0] write_size,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output logic done,
	output logic [2:0] status,
	output logic [3:0] slot,
	output logic [1:0] device_op,
	output logic [BLK_W-1:0] device_block,
	output logic last
);
	bbcp_cmd_t cmd;
	bbcp_sts_t sts;

	assign cfg_ready = 1'b1;

	bbcp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	bbcp_dp #(.SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.req_type(req_type), .block_number(block_number), .slot_index(slot_index),
		.write_size(write_size), .cmd(cmd), .sts(sts), .done(done),
		.status(status), .slot(slot), .device_op(device_op),
		.device_block(device_block), .last(last)
	);
endmodule

// ===== rtl/core/bbcp_chk.sv =====
// Port-level checker of the block buffer cache policy, bound to the top.
module bbcp_chk import bbcp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [2:0] status,
	input logic [1:0] device_op,
	input logic [BLK_W-1:0] device_block,
	input logic last
);
	// accepted item makes the block busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	// a non-final result is followed by busy or another result
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> busy || done) else $error("result chain broken");
	// no device op means no block
	a_blk: assert property (@(posedge clk) disable iff (!arst_n)
		done && device_op == OP_NONE |-> device_block == '0)
		else $error("stray device block");
	// device read only on a fill result
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done && device_op == OP_READ |-> status == ST_MISS && last)
		else $error("bad fill result");
endmodule

bind block_buffer_cache_policy bbcp_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .device_op(device_op), .device_block(device_block), .last(last)
);
